// ----- src/fmpf_pkg.sv -----
// ----------------------------------------------------------------------------
// fmpf_pkg: shared types and constants of the first-match packet filter
// Holds the operation codes, protocol constants and the structs that carry
// a rule, a packet header and a classification token along the cell chain.
// ----------------------------------------------------------------------------
`default_nettype none

package fmpf_pkg;

  // Operation codes carried in the op field of a request.
  typedef enum logic [1:0] {
    OP_CLASSIFY = 2'd0,
    OP_ADD      = 2'd1,
    OP_CLEAR    = 2'd2
  } op_e;

  localparam logic [7:0] PROTO_TCP = 8'd6;
  localparam logic [7:0] PROTO_UDP = 8'd17;
  localparam logic [7:0] TCP_SYN   = 8'h02;

  // One stored filter rule.
  typedef struct packed {
    logic [31:0] src_addr;
    logic [31:0] src_mask;
    logic [31:0] dst_addr;
    logic [31:0] dst_mask;
    logic [15:0] src_port;
    logic [15:0] dst_port;
    logic [7:0]  protocol;
    logic        drop;
  } rule_t;

  // Packet header fields that take part in matching.
  typedef struct packed {
    logic [31:0] src_ip;
    logic [31:0] dst_ip;
    logic [15:0] src_port;
    logic [15:0] dst_port;
    logic [7:0]  protocol;
  } hdr_t;

  // Classification token handed from cell to cell.
  typedef struct packed {
    logic valid;
    logic decided;
    logic verdict;
    hdr_t hdr;
  } tok_t;

endpackage

`default_nettype wire

// ----- src/fmpf_if.sv -----
// ----------------------------------------------------------------------------
// fmpf_if: request and response channels of the first-match packet filter
// Valid/ready channels; a transfer happens when valid and ready are both high.
// ----------------------------------------------------------------------------
`default_nettype none

interface fmpf_req_if;
  logic        valid;
  logic        ready;
  logic [1:0]  op;
  logic [31:0] src_ip;
  logic [31:0] dst_ip;
  logic [31:0] src_mask;
  logic [31:0] dst_mask;
  logic [15:0] src_port;
  logic [15:0] dst_port;
  logic [7:0]  protocol;
  logic [7:0]  tcp_flags;
  logic        drop_rule;

  modport source (
    output valid, op, src_ip, dst_ip, src_mask, dst_mask, src_port, dst_port,
    output protocol, tcp_flags, drop_rule,
    input  ready
  );
  modport sink (
    input  valid, op, src_ip, dst_ip, src_mask, dst_mask, src_port, dst_port,
    input  protocol, tcp_flags, drop_rule,
    output ready
  );
endinterface

interface fmpf_rsp_if;
  logic valid;
  logic ready;
  logic action;
  logic status;

  modport source (output valid, action, status, input ready);
  modport sink (input valid, action, status, output ready);
endinterface

`default_nettype wire

// ----- src/first_match_packet_filter.sv -----
// ----------------------------------------------------------------------------
// first_match_packet_filter: ordered five-tuple rule table, first match wins
// Adds rules, clears the table and classifies packet headers against a row
// of rule cells through which each classify that needs a rule lookup walks.
// ----------------------------------------------------------------------------
// Each request carries one operation and gets exactly one response. An add
// appends the rule at the end of the table (status 1 and no change when the
// table already holds MAX_RULES rules), a clear empties the table, and a
// classify walks a token through a chain of MAX_RULES cells, one cell per
// cycle, where the first valid rule that matches fixes the verdict. Add,
// clear, and any classify that needs no rule lookup (filtering disabled, TCP
// without SYN, empty table) answer without the chain, so one such request
// can be taken per cycle while the response side keeps up. A classify that
// looks up rules occupies the chain: its response is registered (via ST_HOLD
// while the response register is busy) once the token leaves the last cell;
// the next request is accepted only after the return to ST_IDLE, so none is
// taken during the walk. The response register lets a request be accepted
// while the previous response still waits to be taken. The user must write
// filter_enable (cfg_we_i, cfg_wdata_i) only while no request is in flight;
// the block does not enforce this. Its reset value 0 forwards every packet.
// ----------------------------------------------------------------------------
`default_nettype none

module first_match_packet_filter
  import fmpf_pkg::*;
#(
  parameter int unsigned MAX_RULES = 16
) (
  input  wire         clk_i,
  input  wire         rst_ni,
  fmpf_req_if.sink    req,
  fmpf_rsp_if.source  rsp,
  input  wire         cfg_we_i,
  input  wire         cfg_wdata_i
);

  localparam int unsigned CNT_W = $clog2(MAX_RULES + 1);
  localparam logic [CNT_W-1:0] FULL = CNT_W'(MAX_RULES);

  typedef enum logic [1:0] {
    ST_IDLE,   // ready for a request
    ST_WALK,   // classify token travels the chain
    ST_HOLD    // response waits for the response register to free up
  } state_e;

  state_e           state_q, state_d;
  logic [CNT_W-1:0] count_q, count_d;
  logic             enable_q, enable_d;
  logic             out_valid_q, out_valid_d;
  logic             out_action_q, out_action_d;
  logic             out_status_q, out_status_d;
  logic             hold_action_q, hold_action_d;
  logic             hold_status_q, hold_status_d;

  logic             accept;
  logic             out_free;
  logic             is_add;
  logic             table_full;
  logic             bypass;
  logic             launch;
  logic             imm_status;
  rule_t            new_rule;

  tok_t             tok [MAX_RULES+1];
  logic [CNT_W-1:0] rem [MAX_RULES+1];

  assign req.ready = (state_q == ST_IDLE);
  assign accept    = req.valid && req.ready;
  assign out_free  = !out_valid_q || rsp.ready;

  assign is_add     = (req.op == OP_ADD);
  assign table_full = (count_q == FULL);
  assign imm_status = is_add && table_full;

  // A classify skips the chain when filtering is off, when it is TCP without
  // SYN, or when the table holds no rule; in every such case it forwards.
  assign bypass = !enable_q ||
                  ((req.protocol == PROTO_TCP) && ((req.tcp_flags & TCP_SYN) == '0)) ||
                  (count_q == '0);
  assign launch = accept && (req.op == OP_CLASSIFY) && !bypass;

  always_comb begin
    new_rule.src_addr = req.src_ip;
    new_rule.src_mask = req.src_mask;
    new_rule.dst_addr = req.dst_ip;
    new_rule.dst_mask = req.dst_mask;
    new_rule.src_port = req.src_port;
    new_rule.dst_port = req.dst_port;
    new_rule.protocol = req.protocol;
    new_rule.drop     = req.drop_rule;
  end

  // The token that enters the chain carries the packet header and starts
  // undecided; the remaining count starts at the number of valid rules.
  assign tok[0] = '{valid: launch, decided: 1'b0, verdict: 1'b0,
                    hdr: '{src_ip: req.src_ip, dst_ip: req.dst_ip,
                           src_port: req.src_port, dst_port: req.dst_port,
                           protocol: req.protocol}};
  assign rem[0] = count_q;

  // The rule cells; a new rule lands in the cell whose index equals the count.
  for (genvar k = 0; k < MAX_RULES; k++) begin : g_cell
    logic wr_en;
    assign wr_en = accept && is_add && !table_full && (count_q == CNT_W'(k));

    fmpf_cell #(
      .CNT_W (CNT_W)
    ) u_cell (
      .clk_i     (clk_i),
      .rst_ni    (rst_ni),
      .wr_en_i   (wr_en),
      .wr_rule_i (new_rule),
      .tok_i     (tok[k]),
      .rem_i     (rem[k]),
      .tok_o     (tok[k+1]),
      .rem_o     (rem[k+1])
    );
  end

  always_comb begin
    state_d       = state_q;
    count_d       = count_q;
    enable_d      = cfg_we_i ? cfg_wdata_i : enable_q;
    out_valid_d   = out_valid_q && !rsp.ready;
    out_action_d  = out_action_q;
    out_status_d  = out_status_q;
    hold_action_d = hold_action_q;
    hold_status_d = hold_status_q;

    if (accept) begin
      case (req.op)
        OP_ADD: begin
          if (!table_full) begin
            count_d = count_q + CNT_W'(1);
          end
        end
        OP_CLEAR: begin
          count_d = '0;
        end
        default: begin
        end
      endcase
    end

    case (state_q)
      ST_IDLE: begin
        if (accept) begin
          if (launch) begin
            state_d = ST_WALK;
          end else if (out_free) begin
            out_valid_d  = 1'b1;
            out_action_d = 1'b0;
            out_status_d = imm_status;
          end else begin
            hold_action_d = 1'b0;
            hold_status_d = imm_status;
            state_d       = ST_HOLD;
          end
        end
      end
      ST_WALK: begin
        if (tok[MAX_RULES].valid) begin
          if (out_free) begin
            out_valid_d  = 1'b1;
            out_action_d = tok[MAX_RULES].verdict;
            out_status_d = 1'b0;
            state_d      = ST_IDLE;
          end else begin
            hold_action_d = tok[MAX_RULES].verdict;
            hold_status_d = 1'b0;
            state_d       = ST_HOLD;
          end
        end
      end
      ST_HOLD: begin
        if (out_free) begin
          out_valid_d  = 1'b1;
          out_action_d = hold_action_q;
          out_status_d = hold_status_q;
          state_d      = ST_IDLE;
        end
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q       <= ST_IDLE;
      count_q       <= '0;
      enable_q      <= 1'b0;
      out_valid_q   <= 1'b0;
      out_action_q  <= 1'b0;
      out_status_q  <= 1'b0;
      hold_action_q <= 1'b0;
      hold_status_q <= 1'b0;
    end else begin
      state_q       <= state_d;
      count_q       <= count_d;
      enable_q      <= enable_d;
      out_valid_q   <= out_valid_d;
      out_action_q  <= out_action_d;
      out_status_q  <= out_status_d;
      hold_action_q <= hold_action_d;
      hold_status_q <= hold_status_d;
    end
  end

  assign rsp.valid  = out_valid_q;
  assign rsp.action = out_action_q;
  assign rsp.status = out_status_q;

`ifndef SYNTHESIS
  // The rule count never passes the table size.
  a_count_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    count_q <= FULL)
    else $error("rule count exceeds table size");

  // An add to a full table leaves the count unchanged.
  a_full_add: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (accept && is_add && table_full) |=> (count_q == $past(count_q)))
    else $error("add to full table changed the rule count");

  // A token leaves the chain only while a classify request is walking it.
  a_tail_walk: assert property (@(posedge clk_i) disable iff (!rst_ni)
    tok[MAX_RULES].valid |-> (state_q == ST_WALK))
    else $error("token left the chain outside a walk");

  // Every valid rule has been tried by the time the token reaches the end.
  a_tail_rem: assert property (@(posedge clk_i) disable iff (!rst_ni)
    tok[MAX_RULES].valid |-> (rem[MAX_RULES] == '0))
    else $error("token reached the end with rules left to try");

  // A token that matched nothing carries the forward verdict.
  a_tail_fwd: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (tok[MAX_RULES].valid && !tok[MAX_RULES].decided) |-> !tok[MAX_RULES].verdict)
    else $error("unmatched token carries a drop verdict");
`endif

endmodule

`default_nettype wire

// ----- src/fmpf_cell.sv -----
// ----------------------------------------------------------------------------
// fmpf_cell: one rule slot of the classifier chain
// Stores one rule, tests the passing token against it and registers the
// token, with its count of rules still to try, for the next cell.
// ----------------------------------------------------------------------------
`default_nettype none

module fmpf_cell
  import fmpf_pkg::*;
#(
  parameter int unsigned CNT_W = 5
) (
  input  wire              clk_i,
  input  wire              rst_ni,
  input  wire              wr_en_i,
  input  rule_t            wr_rule_i,
  input  tok_t             tok_i,
  input  wire  [CNT_W-1:0] rem_i,
  output tok_t             tok_o,
  output logic [CNT_W-1:0] rem_o
);

  rule_t            rule_q;
  tok_t             tok_d;
  logic             valid_q;
  logic             decided_q;
  logic             verdict_q;
  hdr_t             hdr_q;
  logic [CNT_W-1:0] rem_q, rem_d;
  logic             is_l4;
  logic             hit;
  logic             active;

  always_comb begin
    is_l4 = (tok_i.hdr.protocol == PROTO_TCP) || (tok_i.hdr.protocol == PROTO_UDP);
    hit = ((rule_q.protocol == '0) || (rule_q.protocol == tok_i.hdr.protocol)) &&
          ((rule_q.src_addr == '0) ||
           ((tok_i.hdr.src_ip & rule_q.src_mask) == rule_q.src_addr)) &&
          ((rule_q.dst_addr == '0) ||
           ((tok_i.hdr.dst_ip & rule_q.dst_mask) == rule_q.dst_addr)) &&
          (!is_l4 ||
           (((rule_q.src_port == '0) || (rule_q.src_port == tok_i.hdr.src_port)) &&
            ((rule_q.dst_port == '0) || (rule_q.dst_port == tok_i.hdr.dst_port))));
    // The slot takes part only while it holds one of the valid rules.
    active = tok_i.valid && (rem_i != '0) && !tok_i.decided;

    tok_d = tok_i;
    if (active && hit) begin
      tok_d.decided = 1'b1;
      tok_d.verdict = rule_q.drop;
    end
    rem_d = (rem_i != '0) ? rem_i - CNT_W'(1) : rem_i;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else begin
      valid_q <= tok_d.valid;
    end
  end

  always_ff @(posedge clk_i) begin
    decided_q <= tok_d.decided;
    verdict_q <= tok_d.verdict;
    hdr_q     <= tok_d.hdr;
    rem_q     <= rem_d;
    if (wr_en_i) begin
      rule_q <= wr_rule_i;
    end
  end

  assign tok_o = '{valid: valid_q, decided: decided_q, verdict: verdict_q, hdr: hdr_q};
  assign rem_o = rem_q;

endmodule

`default_nettype wire

// ----- test/tb_first_match_packet_filter.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_first_match_packet_filter: self-checking bench of the first-match filter
// Sends add, clear, classify and unused-op requests with random idling on both channels.
// It predicts every response from its own copy of the rule list and the
// enable bit, and checks each response, field by field, against the oldest
// prediction.
// ----------------------------------------------------------------------------
module tb_first_match_packet_filter;
  import fmpf_pkg::*;

  localparam int unsigned MAX_RULES      = 16;
  localparam int          CLK_HALF       = 10;
  localparam int          IDLE_PCT       = 36;
  // The pause before a register write and at the end of the run covers the time
  // that a classify holds the cell chain, with some margin.
  localparam int          DRAIN_CYCLES   = MAX_RULES + 4;
  // Cycles without any transfer before the run is declared hung. The slowest
  // correct request (chain latency, long sender gap, long receiver stall)
  // stays well below this limit.
  localparam int          WATCHDOG_LIMIT = 2000;
  localparam int          MAX_REPORTS    = 40;
  localparam int unsigned PHASE_ITEMS    = 105;
  localparam int unsigned NUM_PHASES     = 5;
  // Filtering setting of each random phase, phase 0 in the lowest bit.
  localparam logic [NUM_PHASES-1:0] PHASE_ENABLE = 5'b10110;
  // The op field has one code that the filter does not use. The filter must
  // leave its state alone and answer forward with status ok.
  localparam logic [1:0]  OP_UNUSED      = 2'd3;

  // One request as it crosses the request channel.
  typedef struct packed {
    logic [1:0]  op;
    logic [31:0] src_ip;
    logic [31:0] dst_ip;
    logic [31:0] src_mask;
    logic [31:0] dst_mask;
    logic [15:0] src_port;
    logic [15:0] dst_port;
    logic [7:0]  protocol;
    logic [7:0]  tcp_flags;
    logic        drop_rule;
  } filter_req_t;

  // One response as it crosses the response channel.
  typedef struct packed {
    logic action;
    logic status;
  } filter_rsp_t;

  // --------------------------------------------------------------------------
  // Scoreboard. It keeps its own rule list, rule count and enable bit. It
  // turns every accepted request into the response the filter owes for it,
  // and it checks the responses in order.
  // --------------------------------------------------------------------------
  class filter_scoreboard;
    rule_t       rules [MAX_RULES];
    int unsigned rule_count;
    bit          filter_on;
    filter_rsp_t awaited_q [$];
    int unsigned mismatches;

    function new();
      rule_count = 0;
      filter_on  = 1'b0;
      mismatches = 0;
    endfunction

    function void set_filter_on(bit on);
      filter_on = on;
    endfunction

    function int unsigned pending();
      return awaited_q.size();
    endfunction

    // A zero address, port or protocol in a rule matches anything. Ports are
    // looked at only for TCP and UDP packets.
    function bit rule_hits(rule_t r, filter_req_t p);
      bit has_ports;
      has_ports = (p.protocol == PROTO_TCP) || (p.protocol == PROTO_UDP);
      if (r.protocol != 8'd0 && r.protocol != p.protocol) return 1'b0;
      if (r.src_addr != 32'd0 && (p.src_ip & r.src_mask) != r.src_addr) return 1'b0;
      if (r.dst_addr != 32'd0 && (p.dst_ip & r.dst_mask) != r.dst_addr) return 1'b0;
      if (has_ports) begin
        if (r.src_port != 16'd0 && r.src_port != p.src_port) return 1'b0;
        if (r.dst_port != 16'd0 && r.dst_port != p.dst_port) return 1'b0;
      end
      return 1'b1;
    endfunction

    function logic first_match_verdict(filter_req_t p);
      if (!filter_on) return 1'b0;
      // A TCP segment without SYN belongs to an open connection. It passes
      // without any rule being consulted.
      if (p.protocol == PROTO_TCP && (p.tcp_flags & TCP_SYN) == 8'd0) return 1'b0;
      for (int unsigned k = 0; k < rule_count; k++) begin
        if (rule_hits(rules[k], p)) return rules[k].drop;
      end
      return 1'b0;
    endfunction

    function void note_request(filter_req_t p);
      filter_rsp_t rsp;
      rsp = '0;
      case (p.op)
        OP_CLASSIFY: rsp.action = first_match_verdict(p);
        OP_ADD: begin
          if (rule_count >= MAX_RULES) begin
            rsp.status = 1'b1;
          end else begin
            rules[rule_count] = '{src_addr: p.src_ip,   src_mask: p.src_mask,
                                  dst_addr: p.dst_ip,   dst_mask: p.dst_mask,
                                  src_port: p.src_port, dst_port: p.dst_port,
                                  protocol: p.protocol, drop: p.drop_rule};
            rule_count++;
          end
        end
        OP_CLEAR: rule_count = 0;
        default: ;
      endcase
      awaited_q.push_back(rsp);
    endfunction

    task report_mismatch(string msg);
      mismatches++;
      if (mismatches <= MAX_REPORTS) $display("[%0t] mismatch: %s", $time, msg);
    endtask

    task check_response(filter_rsp_t got);
      filter_rsp_t want;
      if (awaited_q.size() == 0) begin
        report_mismatch($sformatf("response with no request pending (action %0b status %0b)",
                                  got.action, got.status));
        return;
      end
      want = awaited_q.pop_front();
      if (got.action !== want.action)
        report_mismatch($sformatf("action %0b, predicted %0b", got.action, want.action));
      if (got.status !== want.status)
        report_mismatch($sformatf("status %0b, predicted %0b", got.status, want.status));
    endtask
  endclass

  // --------------------------------------------------------------------------
  // Clock, reset, channels and the block itself.
  // --------------------------------------------------------------------------
  logic clk_i = 1'b0;
  logic rst_ni;
  logic cfg_we_i;
  logic cfg_wdata_i;

  // When set, neither side idles. One random phase runs this way so that the
  // filter also sees back-to-back traffic.
  bit no_idle;
  int quiet_cycles;

  filter_scoreboard sb;
  filter_req_t      issued_adds [$];  // add requests now held in the rule list
  filter_req_t      req_seen;

  fmpf_req_if req_ch ();
  fmpf_rsp_if rsp_ch ();

  first_match_packet_filter #(
    .MAX_RULES (MAX_RULES)
  ) uut (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .req         (req_ch),
    .rsp         (rsp_ch),
    .cfg_we_i    (cfg_we_i),
    .cfg_wdata_i (cfg_wdata_i)
  );

  always #(CLK_HALF) clk_i = ~clk_i;

  assign req_seen = '{op: req_ch.op, src_ip: req_ch.src_ip, dst_ip: req_ch.dst_ip,
                      src_mask: req_ch.src_mask, dst_mask: req_ch.dst_mask,
                      src_port: req_ch.src_port, dst_port: req_ch.dst_port,
                      protocol: req_ch.protocol, tcp_flags: req_ch.tcp_flags,
                      drop_rule: req_ch.drop_rule};

  // The response side stalls in about a third of the cycles.
  always @(posedge clk_i) begin
    rsp_ch.ready <= no_idle || ($urandom_range(99) >= IDLE_PCT);
  end

  // Both channels are sampled at the rising edge. All inputs change through
  // nonblocking assignments at the same edge, so the values seen here are
  // the ones that were present during the cycle that just ended. The
  // watchdog counts the cycles in which neither channel moves anything.
  always @(posedge clk_i) begin
    if (rst_ni) begin
      if (req_ch.valid && req_ch.ready) sb.note_request(req_seen);
      if (rsp_ch.valid && rsp_ch.ready)
        sb.check_response('{action: rsp_ch.action, status: rsp_ch.status});
      if ((req_ch.valid && req_ch.ready) || (rsp_ch.valid && rsp_ch.ready)) begin
        quiet_cycles <= 0;
      end else if (quiet_cycles + 1 >= WATCHDOG_LIMIT) begin
        $display("FAILED: results differ");
        $finish;
      end else begin
        quiet_cycles <= quiet_cycles + 1;
      end
    end
  end

  // --------------------------------------------------------------------------
  // Request generation.
  // --------------------------------------------------------------------------
  function automatic logic [31:0] prefix_mask(int unsigned len);
    return (len == 0) ? 32'd0 : (~32'd0 << (32 - len));
  endfunction

  // Every field gets a fresh random value, so each bit takes both values
  // across the run, including the bits that the chosen op ignores.
  function automatic filter_req_t random_fields();
    filter_req_t r;
    r.op        = 2'($urandom_range(3));
    r.src_ip    = $urandom();
    r.dst_ip    = $urandom();
    r.src_mask  = $urandom();
    r.dst_mask  = $urandom();
    r.src_port  = 16'($urandom());
    r.dst_port  = 16'($urandom());
    r.protocol  = 8'($urandom());
    r.tcp_flags = 8'($urandom());
    r.drop_rule = 1'($urandom());
    return r;
  endfunction

  function automatic logic [7:0] pick_protocol();
    case ($urandom_range(9))
      0, 1, 2, 3: return PROTO_TCP;
      4, 5, 6:    return PROTO_UDP;
      default:    return 8'($urandom());
    endcase
  endfunction

  // A rule address is a wildcard, a prefix aligned to its mask, or now and
  // then a value that lies outside the mask. The last one can never match.
  function automatic void shape_rule_addr(inout logic [31:0] addr, inout logic [31:0] mask);
    case ($urandom_range(9))
      0, 1: addr = 32'd0;
      2:    ;
      default: begin
        mask = prefix_mask($urandom_range(32));
        addr = addr & mask;
      end
    endcase
  endfunction

  function automatic filter_req_t random_rule_req();
    filter_req_t r;
    r    = random_fields();
    r.op = OP_ADD;
    shape_rule_addr(r.src_ip, r.src_mask);
    shape_rule_addr(r.dst_ip, r.dst_mask);
    if ($urandom_range(1) == 0) r.src_port = 16'd0;
    if ($urandom_range(1) == 0) r.dst_port = 16'd0;
    r.protocol = ($urandom_range(3) == 0) ? 8'd0 : pick_protocol();
    return r;
  endfunction

  function automatic filter_req_t random_packet();
    filter_req_t p;
    p          = random_fields();
    p.op       = OP_CLASSIFY;
    p.protocol = pick_protocol();
    return p;
  endfunction

  // Builds a packet that the given rule accepts. It then often breaks one
  // field, so that the packet falls through to a later rule or to none.
  function automatic filter_req_t packet_for_rule(filter_req_t rule);
    filter_req_t p;
    int unsigned bit_pos;
    p = random_packet();
    if (rule.src_ip != 32'd0) p.src_ip = rule.src_ip | (p.src_ip & ~rule.src_mask);
    if (rule.dst_ip != 32'd0) p.dst_ip = rule.dst_ip | (p.dst_ip & ~rule.dst_mask);
    if (rule.src_port != 16'd0) p.src_port = rule.src_port;
    if (rule.dst_port != 16'd0) p.dst_port = rule.dst_port;
    if (rule.protocol != 8'd0) p.protocol = rule.protocol;
    if ($urandom_range(99) < 85) p.tcp_flags = p.tcp_flags | TCP_SYN;
    if ($urandom_range(3) == 0) begin
      bit_pos = $urandom_range(31);
      case ($urandom_range(5))
        0: p.src_ip[bit_pos]        = ~p.src_ip[bit_pos];
        1: p.dst_ip[bit_pos]        = ~p.dst_ip[bit_pos];
        2: p.src_port[bit_pos % 16] = ~p.src_port[bit_pos % 16];
        3: p.dst_port[bit_pos % 16] = ~p.dst_port[bit_pos % 16];
        4: p.protocol[bit_pos % 8]  = ~p.protocol[bit_pos % 8];
        default: p.tcp_flags[bit_pos % 8] = ~p.tcp_flags[bit_pos % 8];
      endcase
    end
    return p;
  endfunction

  function automatic filter_req_t make_req(logic [1:0] op, logic [31:0] sip, logic [31:0] smask,
                                           logic [31:0] dip, logic [31:0] dmask,
                                           logic [15:0] sp, logic [15:0] dp,
                                           logic [7:0] proto, logic [7:0] flags, logic drop);
    return '{op: op, src_ip: sip, dst_ip: dip, src_mask: smask, dst_mask: dmask,
             src_port: sp, dst_port: dp, protocol: proto, tcp_flags: flags,
             drop_rule: drop};
  endfunction

  // --------------------------------------------------------------------------
  // Channel drivers.
  // --------------------------------------------------------------------------

  // Presents one request and returns in the time step of the edge that
  // accepted it. valid stays high, so the next request follows without a gap
  // unless the random idling lowers it.
  task automatic drive_request(input filter_req_t r);
    while (!no_idle && $urandom_range(99) < IDLE_PCT) begin
      req_ch.valid <= 1'b0;
      @(posedge clk_i);
    end
    req_ch.valid     <= 1'b1;
    req_ch.op        <= r.op;
    req_ch.src_ip    <= r.src_ip;
    req_ch.dst_ip    <= r.dst_ip;
    req_ch.src_mask  <= r.src_mask;
    req_ch.dst_mask  <= r.dst_mask;
    req_ch.src_port  <= r.src_port;
    req_ch.dst_port  <= r.dst_port;
    req_ch.protocol  <= r.protocol;
    req_ch.tcp_flags <= r.tcp_flags;
    req_ch.drop_rule <= r.drop_rule;
    @(posedge clk_i);
    while (!req_ch.ready) @(posedge clk_i);
  endtask

  // The generator keeps track of which add requests are still in the rule
  // list, so that it can build packets that hit them.
  task automatic issue(input filter_req_t r);
    if (r.op == OP_ADD && issued_adds.size() < MAX_RULES) issued_adds.push_back(r);
    else if (r.op == OP_CLEAR) issued_adds.delete();
    drive_request(r);
  endtask

  // Waits until every response is back and then lets the pause run out, so the
  // filter is idle before write_filter_enable writes the enable register.
  task automatic wait_drained();
    req_ch.valid <= 1'b0;
    do @(posedge clk_i); while (sb.pending() != 0);
    repeat (DRAIN_CYCLES) @(posedge clk_i);
  endtask

  task automatic write_filter_enable(input bit on);
    wait_drained();
    cfg_we_i    <= 1'b1;
    cfg_wdata_i <= on;
    @(posedge clk_i);
    cfg_we_i <= 1'b0;
    sb.set_filter_on(on);
  endtask

  // --------------------------------------------------------------------------
  // Directed requests. They cover the field extremes, every op, a TCP segment
  // without SYN, the port check for UDP and its absence for other protocols,
  // wildcard rules, a full rule list, a clear, and the unused op code.
  // --------------------------------------------------------------------------
  task automatic run_directed();
    // An empty list forwards everything.
    issue(make_req(OP_CLASSIFY, '0, '0, '0, '0, '0, '0, '0, '0, 1'b0));
    // Drop TCP connection attempts from 192.168.0.0/16.
    issue(make_req(OP_ADD, 32'hC0A8_0000, 32'hFFFF_0000, '0, '0, '0, '0,
                   PROTO_TCP, '0, 1'b1));
    issue(make_req(OP_CLASSIFY, 32'hC0A8_0507, '0, 32'h0A00_0001, '0, 16'd1234, 16'd80,
                   PROTO_TCP, TCP_SYN, 1'b0));
    // The same flow with ACK only passes without lookup.
    issue(make_req(OP_CLASSIFY, 32'hC0A8_0507, '0, 32'h0A00_0001, '0, 16'd1234, 16'd80,
                   PROTO_TCP, 8'h10, 1'b0));
    // No rule matches this source.
    issue(make_req(OP_CLASSIFY, 32'h0A00_0001, '0, 32'hC0A8_0507, '0, 16'd1234, 16'd80,
                   PROTO_TCP, 8'hFF, 1'b0));
    // A rule with every field at its maximum. Its ports are not looked at,
    // because protocol 255 is neither TCP nor UDP.
    issue(make_req(OP_ADD, '1, '1, '1, '1, '1, '1, 8'hFF, '1, 1'b1));
    issue(make_req(OP_CLASSIFY, '1, '1, '1, '1, '0, '0, 8'hFF, '1, 1'b0));
    // UDP to port 53 in 10.0.0.0/8 is dropped, while another port passes.
    issue(make_req(OP_ADD, '0, '1, 32'h0A00_0000, 32'hFF00_0000, '0, 16'd53,
                   PROTO_UDP, '0, 1'b1));
    issue(make_req(OP_CLASSIFY, 32'h0101_0101, '0, 32'h0A01_0203, '0, 16'd5000, 16'd53,
                   PROTO_UDP, '0, 1'b0));
    issue(make_req(OP_CLASSIFY, 32'h0101_0101, '0, 32'h0A01_0203, '0, 16'd5000, 16'd54,
                   PROTO_UDP, '0, 1'b0));
    // A full wildcard rule catches everything that is left. Its masks are
    // ignored because both of its addresses are zero.
    issue(make_req(OP_ADD, '0, '1, '0, '1, '0, '0, '0, '0, 1'b1));
    issue(make_req(OP_CLASSIFY, 32'h0808_0808, '0, 32'h0404_0404, '0, '0, '0,
                   8'd1, '0, 1'b0));
    // The unused op changes nothing.
    issue(make_req(OP_UNUSED, '1, '1, '1, '1, '1, '1, '1, '1, 1'b1));
    // Fill the list, then add one rule too many.
    repeat (MAX_RULES - 4 + 1) issue(random_rule_req());
    issue(make_req(OP_CLEAR, '1, '1, '1, '1, '1, '1, '1, '1, 1'b1));
    issue(make_req(OP_CLASSIFY, '1, '1, '1, '1, '0, '0, 8'hFF, '1, 1'b0));
  endtask

  // --------------------------------------------------------------------------
  // Random requests. Most of them come in well-formed sequences: sometimes a
  // clear, then a burst of adds (now and then long enough to overflow the
  // list), then classifies that mostly aim at stored rules. The rest is
  // noise with random ops and fields. Unused-op requests are not counted.
  // --------------------------------------------------------------------------
  task automatic run_random_phase(input int unsigned items);
    int unsigned sent;
    int unsigned burst;
    filter_req_t r;
    sent = 0;
    while (sent < items) begin
      if ($urandom_range(99) < 75) begin
        if ($urandom_range(3) == 0) begin
          r    = random_fields();
          r.op = OP_CLEAR;
          issue(r);
          sent++;
        end
        burst = ($urandom_range(7) == 0) ? $urandom_range(20, 10) : $urandom_range(5, 1);
        repeat (burst) begin
          issue(random_rule_req());
          sent++;
        end
        burst = $urandom_range(12, 3);
        repeat (burst) begin
          if (issued_adds.size() != 0 && $urandom_range(9) < 8)
            r = packet_for_rule(issued_adds[$urandom_range(issued_adds.size() - 1)]);
          else
            r = random_packet();
          issue(r);
          sent++;
        end
      end else begin
        r = random_fields();
        issue(r);
        if (r.op != OP_UNUSED) sent++;
      end
    end
  endtask

  // --------------------------------------------------------------------------
  // Main sequence: reset once, directed requests with filtering on, then
  // random phases under changing enable settings. One phase runs with no
  // idling on either side.
  // --------------------------------------------------------------------------
  initial begin
    sb                = new();
    no_idle           = 1'b0;
    quiet_cycles      = 0;
    rst_ni            = 1'b0;
    cfg_we_i          = 1'b0;
    cfg_wdata_i       = 1'b0;
    rsp_ch.ready      = 1'b0;
    req_ch.valid      = 1'b0;
    req_ch.op         = OP_CLASSIFY;
    req_ch.src_ip     = '0;
    req_ch.dst_ip     = '0;
    req_ch.src_mask   = '0;
    req_ch.dst_mask   = '0;
    req_ch.src_port   = '0;
    req_ch.dst_port   = '0;
    req_ch.protocol   = '0;
    req_ch.tcp_flags  = '0;
    req_ch.drop_rule  = 1'b0;
    repeat (8) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    write_filter_enable(1'b1);
    run_directed();

    for (int unsigned ph = 0; ph < NUM_PHASES; ph++) begin
      write_filter_enable(PHASE_ENABLE[ph]);
      no_idle = (ph == 2);
      run_random_phase(PHASE_ITEMS);
    end
    no_idle = 1'b0;

    wait_drained();
    if (sb.mismatches == 0) begin
      $display("PASSED: all results match");
    end else begin
      $display("FAILED: results differ");
    end
    $finish;
  end

endmodule

// ----- filelist.f -----
src/fmpf_pkg.sv
src/fmpf_if.sv
src/fmpf_cell.sv
src/first_match_packet_filter.sv
test/tb_first_match_packet_filter.sv
